>>> hdl/bfmm_pkg.sv
// ----------------------------------------------------------------------------
// bfmm_pkg
// Shared constants, types and helpers for the 3x3 box mean filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfmm_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int SAMPLE_BITS = 8;

    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int FW_BITS    = $clog2(MAX_WIDTH + 1);
    localparam int MAPW_BITS  = 11;
    localparam int MAPH_BITS  = 16;
    localparam int ROW_BITS   = MAPH_BITS + 1;
    localparam int SCALE_BITS = 16;
    localparam int SUM_BITS   = $clog2(9 * ((1 << SAMPLE_BITS) - 1) + 1);
    localparam int PROD_BITS  = SUM_BITS + SCALE_BITS;
    localparam int RES_BITS   = 24;

    // floor(x / 3) == (x * RECIP3) >> RECIP3_SHIFT for any x below 2^32
    localparam logic [31:0] RECIP3       = 32'hAAAA_AAAB;
    localparam int          RECIP3_SHIFT = 33;

    localparam logic [MAPW_BITS-1:0]  MAP_WIDTH_RESET    = 11'd256;
    localparam logic [MAPH_BITS-1:0]  MAP_HEIGHT_RESET   = 16'd256;
    localparam logic [SCALE_BITS-1:0] HEIGHT_SCALE_RESET = 16'd256;

    localparam logic [1:0] REG_MAP_WIDTH    = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_HEIGHT_SCALE = 2'd2;

    localparam logic [RES_BITS-1:0] MIN_INIT = {RES_BITS{1'b1}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CALC
    } state_t;

    // window update and neighbor select; bit 0 of each mask is the -1 offset
    typedef struct packed {
        logic       shift;
        logic [2:0] row_mask;
        logic [2:0] col_mask;
    } win_ctrl_t;

    typedef struct packed {
        logic                start;
        logic [SUM_BITS-1:0] sum;
        logic [1:0]          sh;
        logic [1:0]          threes;
    } div_req_t;

    function automatic logic [FW_BITS-1:0] clamp_width(input logic [MAPW_BITS-1:0] w);
        logic [FW_BITS-1:0] r;
        if (w == '0)
            r = FW_BITS'(1);
        else if (32'(w) > MAX_WIDTH)
            r = FW_BITS'(MAX_WIDTH);
        else
            r = FW_BITS'(w);
        return r;
    endfunction

endpackage

>>> hdl/bfmm_ram.sv
// ----------------------------------------------------------------------------
// bfmm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/bfmm_window.sv
// ----------------------------------------------------------------------------
// bfmm_window
// Two stored window columns plus the incoming column; masked 3x3 sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfmm_window
    import bfmm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  win_ctrl_t              ctrl,
    input  logic [SAMPLE_BITS-1:0] new_top,
    input  logic [SAMPLE_BITS-1:0] new_mid,
    input  logic [SAMPLE_BITS-1:0] new_bot,
    output logic [SUM_BITS-1:0]    sum
);

    // win_reg[row][0] is the older column, [1] the newer one
    logic [SAMPLE_BITS-1:0] win_reg [3][2];
    logic [SAMPLE_BITS-1:0] new_col [3];
    logic [SUM_BITS-1:0]    row_sum [3];

    assign new_col[0] = new_top;
    assign new_col[1] = new_mid;
    assign new_col[2] = new_bot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= '0;
                win_reg[i][1] <= '0;
            end
        end
        else if (ctrl.shift)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= new_col[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            row_sum[i] = (ctrl.col_mask[0] ? SUM_BITS'(win_reg[i][0]) : '0)
                       + (ctrl.col_mask[1] ? SUM_BITS'(win_reg[i][1]) : '0)
                       + (ctrl.col_mask[2] ? SUM_BITS'(new_col[i])    : '0);
        end
        sum = (ctrl.row_mask[0] ? row_sum[0] : '0)
            + (ctrl.row_mask[1] ? row_sum[1] : '0)
            + (ctrl.row_mask[2] ? row_sum[2] : '0);
    end

endmodule

>>> hdl/bfmm_div.sv
// ----------------------------------------------------------------------------
// bfmm_div
// Scale multiply and division by count = 2^a * 3^b; the /3 passes reuse one
// reciprocal multiplier, one pass per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfmm_div
    import bfmm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  div_req_t              req,
    input  logic [SCALE_BITS-1:0] scale,
    output logic                  done,
    output logic [RES_BITS-1:0]   result
);

    logic [PROD_BITS-1:0]    prod_reg;
    logic [1:0]              cnt_reg;
    logic [PROD_BITS-1:0]    scaled;
    logic [PROD_BITS+31:0]   recip_mul;
    logic [PROD_BITS-1:0]    third;

    assign scaled    = (PROD_BITS'(req.sum) * PROD_BITS'(scale)) >> req.sh;
    assign recip_mul = (PROD_BITS + 32)'(prod_reg) * (PROD_BITS + 32)'(RECIP3);
    assign third     = PROD_BITS'(recip_mul >> RECIP3_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (req.start)
        begin
            cnt_reg <= req.threes;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            prod_reg <= scaled;
        end
        else if (cnt_reg != '0)
        begin
            prod_reg <= third;
        end
    end

    assign done   = (cnt_reg == '0);
    assign result = prod_reg[RES_BITS-1:0];

endmodule

>>> hdl/box_filter_3x3_min_max.sv
// ----------------------------------------------------------------------------
// box_filter_3x3_min_max: 3x3 border-renormalized box mean over a raster stream
// An item that gives no result passes through accept and the line buffer read.
// An item with a result then goes through the scale multiply and zero, one
// or two passes of the shared /3 multiplier, and waits while the output stalls.
// Reset clears control, counters, window and min/max; line buffers are not
// cleared (stale entries are always masked), so there is no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_filter_3x3_min_max
    import bfmm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   cmd,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [RES_BITS-1:0]    filtered_height,
    output logic                   frame_last,
    output logic [RES_BITS-1:0]    min_height,
    output logic [RES_BITS-1:0]    max_height
);

    // configuration
    logic [MAPW_BITS-1:0]  map_width_reg;
    logic [MAPH_BITS-1:0]  map_height_reg;
    logic [SCALE_BITS-1:0] height_scale_reg;
    logic                  cfg_wr;
    logic [1:0]            cfg_idx;

    // control
    state_t                state_reg;
    state_t                state_next;
    logic                  busy_reg;
    logic [FW_BITS-1:0]    fw_reg;
    logic [MAPH_BITS-1:0]  fh_reg;
    logic [ROW_BITS-1:0]   row_reg;
    logic [COL_BITS-1:0]   col_reg;
    logic [SAMPLE_BITS-1:0] bot_reg;
    logic                  last_reg;

    logic                  accept;
    logic                  go;
    logic                  flushing;
    logic [FW_BITS-1:0]    eff_fw;
    logic [MAPH_BITS-1:0]  eff_fh;
    logic [ROW_BITS-1:0]   eff_row;
    logic [COL_BITS-1:0]   eff_col;

    logic                  pre_emit;
    logic                  post_emit;
    logic                  emit;
    logic                  last;
    logic                  col_wrap;
    logic [2:0]            row_mask;
    logic [2:0]            col_mask;
    logic [1:0]            rows_n;
    logic [1:0]            cols_n;

    logic [2*SAMPLE_BITS-1:0] ram_rdata;
    logic                  ram_we;
    logic [SUM_BITS-1:0]   win_sum;
    win_ctrl_t             win_ctrl;
    div_req_t              div_req;
    logic                  div_done;
    logic [RES_BITS-1:0]   div_result;

    logic                  out_free;
    logic                  load_out;
    logic [RES_BITS-1:0]   run_min_reg;
    logic [RES_BITS-1:0]   run_max_reg;
    logic [RES_BITS-1:0]   new_min;
    logic [RES_BITS-1:0]   new_max;

    logic                  out_valid_reg;
    logic [RES_BITS-1:0]   filtered_height_reg;
    logic                  frame_last_reg;
    logic [RES_BITS-1:0]   min_height_reg;
    logic [RES_BITS-1:0]   max_height_reg;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg    <= MAP_WIDTH_RESET;
            map_height_reg   <= MAP_HEIGHT_RESET;
            height_scale_reg <= HEIGHT_SCALE_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_MAP_WIDTH:    map_width_reg    <= pwdata[MAPW_BITS-1:0];
                REG_MAP_HEIGHT:   map_height_reg   <= pwdata[MAPH_BITS-1:0];
                REG_HEIGHT_SCALE: height_scale_reg <= pwdata[SCALE_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_MAP_WIDTH:    prdata = 32'(map_width_reg);
            REG_MAP_HEIGHT:   prdata = 32'(map_height_reg);
            REG_HEIGHT_SCALE: prdata = 32'(height_scale_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- accept decode ----------------
    // the first sample while idle latches the frame size and restarts counters
    assign eff_fw   = busy_reg ? fw_reg  : clamp_width(map_width_reg);
    assign eff_fh   = busy_reg ? fh_reg  : ((map_height_reg == '0) ? MAPH_BITS'(1)
                                                                  : map_height_reg);
    assign eff_row  = busy_reg ? row_reg : '0;
    assign eff_col  = busy_reg ? col_reg : '0;
    assign flushing = (eff_row >= ROW_BITS'(eff_fh));
    assign accept   = in_valid && !in_stall;
    // samples during draining and flush ticks while samples are owed drop out
    assign go       = accept && (busy_reg || !cmd) && (cmd == flushing);

    // ---------------- read-cycle decode ----------------
    always_comb
    begin
        pre_emit  = (col_reg == '0) && (row_reg >= ROW_BITS'(2));
        post_emit = (col_reg != '0) && (row_reg >= ROW_BITS'(1));
        emit      = pre_emit || post_emit;
        last      = pre_emit && (row_reg == ROW_BITS'(fh_reg) + ROW_BITS'(1));
        if (pre_emit)
        begin
            // right-edge pixel two rows up, from the window before the shift
            row_mask = {row_reg <= ROW_BITS'(fh_reg), 1'b1, row_reg >= ROW_BITS'(3)};
            col_mask = {1'b0, 1'b1, fw_reg >= FW_BITS'(2)};
        end
        else
        begin
            row_mask = {row_reg < ROW_BITS'(fh_reg), 1'b1, row_reg >= ROW_BITS'(2)};
            col_mask = {1'b1, 1'b1, col_reg >= COL_BITS'(2)};
        end
        rows_n   = 2'($countones(row_mask));
        cols_n   = 2'($countones(col_mask));
        col_wrap = (FW_BITS'(col_reg) + FW_BITS'(1)) >= fw_reg;
    end

    // ---------------- state machine ----------------
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = go ? S_READ : S_IDLE;
            S_READ:  state_next = emit ? S_CALC : S_IDLE;
            S_CALC:  state_next = (div_done && out_free) ? S_IDLE : S_CALC;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall          = 1'b1;
        ram_we            = 1'b0;
        load_out          = 1'b0;
        win_ctrl.shift    = 1'b0;
        win_ctrl.row_mask = row_mask;
        win_ctrl.col_mask = col_mask;
        div_req.start     = 1'b0;
        div_req.sum       = win_sum;
        div_req.sh        = {1'b0, rows_n == 2'd2} + {1'b0, cols_n == 2'd2};
        div_req.threes    = {1'b0, rows_n == 2'd3} + {1'b0, cols_n == 2'd3};
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
            end
            S_READ:
            begin
                ram_we         = !last;
                win_ctrl.shift = !last;
                div_req.start  = emit;
            end
            S_CALC:
            begin
                load_out = div_done && out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            fw_reg    <= FW_BITS'(1);
            fh_reg    <= MAPH_BITS'(1);
            row_reg   <= '0;
            col_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && go)
            begin
                busy_reg <= 1'b1;
                fw_reg   <= eff_fw;
                fh_reg   <= eff_fh;
                row_reg  <= eff_row;
                col_reg  <= eff_col;
            end
            if (state_reg == S_READ)
            begin
                last_reg <= last;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
                else if (col_wrap)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + ROW_BITS'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && go)
        begin
            bot_reg <= flushing ? '0 : sample;
        end
    end

    // ---------------- line buffers: entry c holds {row r-2, row r-1} ----------------
    bfmm_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata ({ram_rdata[SAMPLE_BITS-1:0], bot_reg}),
        .re    (go),
        .raddr (eff_col),
        .rdata (ram_rdata)
    );

    bfmm_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (win_ctrl),
        .new_top (ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .new_mid (ram_rdata[SAMPLE_BITS-1:0]),
        .new_bot (bot_reg),
        .sum     (win_sum)
    );

    bfmm_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (div_req),
        .scale  (height_scale_reg),
        .done   (div_done),
        .result (div_result)
    );

    // ---------------- min/max and output register ----------------
    assign new_min = (div_result < run_min_reg) ? div_result : run_min_reg;
    assign new_max = (div_result > run_max_reg) ? div_result : run_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            run_min_reg   <= MIN_INIT;
            run_max_reg   <= '0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
            if (last_reg)
            begin
                run_min_reg <= MIN_INIT;
                run_max_reg <= '0;
            end
            else
            begin
                run_min_reg <= new_min;
                run_max_reg <= new_max;
            end
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            filtered_height_reg <= div_result;
            frame_last_reg      <= last_reg;
            min_height_reg      <= last_reg ? new_min : '0;
            max_height_reg      <= last_reg ? new_max : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign filtered_height = filtered_height_reg;
    assign frame_last      = frame_last_reg;
    assign min_height      = min_height_reg;
    assign max_height      = max_height_reg;

`ifndef SYNTH
    a_read_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> $past(state_reg) == S_IDLE && $past(accept))
        else $error("line buffer read cycle without an accepted item");

    a_last_brackets: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_last |->
            min_height <= filtered_height && filtered_height <= max_height)
        else $error("frame min/max do not bracket the final item");

    a_nonlast_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_last |-> min_height == '0 && max_height == '0)
        else $error("min/max nonzero on an item that is not the last");

    a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !(out_valid_reg && out_stall))
        else $error("output register overwritten while stalled");
`endif

endmodule

>>> tb/bfmm_tb_pkg.sv
// ----------------------------------------------------------------------------
// bfmm_tb_pkg
// Item codes shared by the box filter stimulus and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfmm_tb_pkg;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_FLUSH  = 1'b1
    } height_cmd_t;

endpackage

>>> tb/box_filter_3x3_min_max_checker.sv
// ----------------------------------------------------------------------------
// box_filter_3x3_min_max_checker
// Watches the register port and both item channels of the box filter, keeps
// its own line buffers, window and frame counters, predicts each filtered
// height and the end-of-frame min/max, and compares them in order with what
// the block delivers. Register reads are checked against shadow copies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_filter_3x3_min_max_checker
    import bfmm_pkg::*, bfmm_tb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic                   pready,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    input  logic [31:0]            prdata,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic                   cmd,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [RES_BITS-1:0]    filtered_height,
    input  logic                   frame_last,
    input  logic [RES_BITS-1:0]    min_height,
    input  logic [RES_BITS-1:0]    max_height,
    output int                     heights_owed,
    output int                     mismatch_count
);

    typedef struct packed {
        logic [RES_BITS-1:0] height;
        logic                last;
        logic [RES_BITS-1:0] lo;
        logic [RES_BITS-1:0] hi;
    } height_result_t;

    height_result_t         expected_heights[$];

    logic [SAMPLE_BITS-1:0] line_buf [2*MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] win [3][3];
    logic [FW_BITS-1:0]     col_idx;
    logic [ROW_BITS-1:0]    row_idx;
    logic [FW_BITS-1:0]     frame_w;
    logic [ROW_BITS-1:0]    frame_h;
    logic                   in_frame;
    logic [RES_BITS-1:0]    frame_min;
    logic [RES_BITS-1:0]    frame_max;

    logic [MAPW_BITS-1:0]   width_reg;
    logic [MAPH_BITS-1:0]   height_reg;
    logic [SCALE_BITS-1:0]  scale_reg;

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    // mean over the in-bounds taps; window column ctr holds image column cc
    function automatic logic [RES_BITS-1:0] window_mean(input int cr, input int cc,
                                                         input int ctr);
        int unsigned total;
        int unsigned taps;
        int          dy;
        int          dx;
        int          ry;
        int          rx;
        int          k;
        total = 0;
        taps  = 0;
        for (dy = -1; dy <= 1; dy++)
        begin
            ry = cr + dy;
            if (ry < 0 || ry >= int'(frame_h))
                continue;
            for (dx = -1; dx <= 1; dx++)
            begin
                k  = ctr + dx;
                rx = cc + dx;
                if (k < 0 || k > 2 || rx < 0 || rx >= int'(frame_w))
                    continue;
                total += win[dy + 1][k];
                taps++;
            end
        end
        if (taps == 0)
            taps = 1;
        return RES_BITS'((total * scale_reg) / taps);
    endfunction

    task automatic log_height(input logic [RES_BITS-1:0] v, input logic closing);
        height_result_t r;
        if (v < frame_min)
            frame_min = v;
        if (v > frame_max)
            frame_max = v;
        r = '{height: v, last: 1'b0, lo: '0, hi: '0};
        if (closing)
        begin
            r.last    = 1'b1;
            r.lo      = frame_min;
            r.hi      = frame_max;
            frame_min = MIN_INIT;
            frame_max = '0;
        end
        expected_heights.push_back(r);
    endtask

    task automatic filter_step(input logic c_in, input logic [SAMPLE_BITS-1:0] smp);
        logic                   draining;
        logic                   closing;
        logic [SAMPLE_BITS-1:0] top_px;
        logic [SAMPLE_BITS-1:0] mid_px;
        logic [SAMPLE_BITS-1:0] bot_px;
        int                     i;
        if (!in_frame)
        begin
            if (c_in == CMD_FLUSH)
                return;
            if (width_reg == '0)
                frame_w = FW_BITS'(1);
            else if (int'(width_reg) > MAX_WIDTH)
                frame_w = FW_BITS'(MAX_WIDTH);
            else
                frame_w = FW_BITS'(width_reg);
            frame_h  = (height_reg == '0) ? ROW_BITS'(1) : ROW_BITS'(height_reg);
            row_idx  = '0;
            col_idx  = '0;
            in_frame = 1'b1;
        end
        draining = (row_idx >= frame_h);
        // samples past the frame end and flushes while samples are owed are dropped
        if ((c_in == CMD_FLUSH) != draining)
            return;

        // right-edge pixel two rows up, taken before the window shifts
        if (col_idx == '0 && row_idx >= 2)
        begin
            closing = (row_idx == frame_h + 1'b1);
            log_height(window_mean(int'(row_idx) - 2, int'(frame_w) - 1, 2), closing);
            if (closing)
            begin
                in_frame = 1'b0;
                return;
            end
        end

        top_px = line_buf[col_idx];
        mid_px = line_buf[MAX_WIDTH + col_idx];
        bot_px = draining ? '0 : smp;
        for (i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = top_px;
        win[1][2] = mid_px;
        win[2][2] = bot_px;
        line_buf[col_idx]             = mid_px;
        line_buf[MAX_WIDTH + col_idx] = bot_px;

        if (col_idx >= 1 && row_idx >= 1)
            log_height(window_mean(int'(row_idx) - 1, int'(col_idx) - 1, 1), 1'b0);

        col_idx++;
        if (col_idx >= frame_w)
        begin
            col_idx = '0;
            row_idx++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        height_result_t want;
        logic [31:0]    read_want;
        int             i;
        if (!rst_n)
        begin
            expected_heights.delete();
            for (i = 0; i < 2 * MAX_WIDTH; i++)
                line_buf[i] = '0;
            for (i = 0; i < 9; i++)
                win[i / 3][i % 3] = '0;
            col_idx      = '0;
            row_idx      = '0;
            frame_w      = FW_BITS'(1);
            frame_h      = ROW_BITS'(1);
            in_frame     = 1'b0;
            frame_min    = MIN_INIT;
            frame_max    = '0;
            width_reg    = MAP_WIDTH_RESET;
            height_reg   = MAP_HEIGHT_RESET;
            scale_reg    = HEIGHT_SCALE_RESET;
            heights_owed <= 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[3:2])
                        REG_MAP_WIDTH:    width_reg  = pwdata[MAPW_BITS-1:0];
                        REG_MAP_HEIGHT:   height_reg = pwdata[MAPH_BITS-1:0];
                        REG_HEIGHT_SCALE: scale_reg  = pwdata[SCALE_BITS-1:0];
                        default: ;
                    endcase
                end
                else
                begin
                    case (paddr[3:2])
                        REG_MAP_WIDTH:    read_want = 32'(width_reg);
                        REG_MAP_HEIGHT:   read_want = 32'(height_reg);
                        REG_HEIGHT_SCALE: read_want = 32'(scale_reg);
                        default:          read_want = prdata;
                    endcase
                    if (prdata !== read_want)
                        note_mismatch("register readback", read_want, prdata);
                end
            end

            if (out_valid && !out_stall)
            begin
                if (expected_heights.size() == 0)
                    note_mismatch("unexpected item", '0, 32'(filtered_height));
                else
                begin
                    want = expected_heights.pop_front();
                    if (filtered_height !== want.height)
                        note_mismatch("filtered_height", 32'(want.height),
                                      32'(filtered_height));
                    if (frame_last !== want.last)
                        note_mismatch("frame_last", 32'(want.last), 32'(frame_last));
                    if (min_height !== want.lo)
                        note_mismatch("min_height", 32'(want.lo), 32'(min_height));
                    if (max_height !== want.hi)
                        note_mismatch("max_height", 32'(want.hi), 32'(max_height));
                end
            end

            if (in_valid && !in_stall)
                filter_step(cmd, sample);

            heights_owed <= expected_heights.size();
        end
    end

endmodule

>>> tb/box_filter_3x3_min_max_test.sv
// ----------------------------------------------------------------------------
// box_filter_3x3_min_max_test
// Drives raster frames of height samples and flush ticks into the box filter
// with random gaps and output stalls, reprograms the frame size and scale
// between phases, and reports the checker's verdict. A short directed set
// covers the extreme sizes, scales and samples and the dropped-item cases,
// then random frames fill out the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_filter_3x3_min_max_test;

    import bfmm_pkg::*;
    import bfmm_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int RANDOM_ITEMS = 300;
    localparam int DRAIN_CYCLES = 8;

    typedef enum {
        FILL_RANDOM,
        FILL_EXTREME,
        FILL_MAX
    } fill_t;

    logic                   clk             = 1'b0;
    logic                   rst_n           = 1'b0;
    logic                   psel            = 1'b0;
    logic                   penable         = 1'b0;
    logic                   pwrite          = 1'b0;
    logic [3:0]             paddr           = '0;
    logic [31:0]            pwdata          = '0;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   in_valid        = 1'b0;
    logic                   in_stall;
    logic                   cmd             = 1'b0;
    logic [SAMPLE_BITS-1:0] sample          = '0;
    logic                   out_valid;
    logic                   out_stall       = 1'b0;
    logic [RES_BITS-1:0]    filtered_height;
    logic                   frame_last;
    logic [RES_BITS-1:0]    min_height;
    logic [RES_BITS-1:0]    max_height;

    int                     heights_owed;
    int                     mismatch_count;
    int                     cycle_count     = 0;
    int                     counted         = 0;
    bit                     quiet           = 1'b0;
    int unsigned            cur_w           = 256;
    int unsigned            cur_h           = 256;

    box_filter_3x3_min_max DUT (.*);

    box_filter_3x3_min_max_checker u_checker (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("box_filter_3x3_min_max regression: fail");
            $finish;
        end
    end

    // output side: random stall before each item, none when quiet
    initial
    begin : result_sink
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = quiet ? 0 : $urandom_range(0, 10);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic apb_access(input logic is_write, input logic [1:0] idx,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_regs(input int unsigned w, input int unsigned h,
                                input logic [15:0] scale);
        apb_access(1'b1, REG_MAP_WIDTH, 32'(w));
        apb_access(1'b1, REG_MAP_HEIGHT, 32'(h));
        apb_access(1'b1, REG_HEIGHT_SCALE, 32'(scale));
        apb_access(1'b0, REG_MAP_WIDTH, '0);
        apb_access(1'b0, REG_MAP_HEIGHT, '0);
        apb_access(1'b0, REG_HEIGHT_SCALE, '0);
        cur_w = w;
        cur_h = h;
    endtask

    task automatic random_regs();
        int unsigned w;
        int unsigned h;
        logic [15:0] scale;
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 64) : $urandom_range(2, 12);
        h = $urandom_range(2, 10);
        case ($urandom_range(0, 3))
            0:       scale = 16'h0000;
            1:       scale = 16'hFFFF;
            2:       scale = 16'h0100;
            default: scale = 16'($urandom);
        endcase
        program_regs(w, h, scale);
    endtask

    // hold the input off until every owed height has arrived
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (heights_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_item(input height_cmd_t c, input logic [SAMPLE_BITS-1:0] s);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        sample   <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input fill_t fill);
        logic [SAMPLE_BITS-1:0] s;
        case (fill)
            FILL_EXTREME: s = $urandom_range(0, 1) ? '1 : '0;
            FILL_MAX:     s = '1;
            default:      s = SAMPLE_BITS'($urandom);
        endcase
        return s;
    endfunction

    // one frame at the current size; noise items are ones the block drops
    task automatic run_frame(input int noise_pct, input fill_t fill, input bit mid_cfg);
        int fw;
        int fh;
        int total;
        fw    = (cur_w == 0) ? 1 : ((cur_w > MAX_WIDTH) ? MAX_WIDTH : int'(cur_w));
        fh    = (cur_h == 0) ? 1 : int'(cur_h);
        total = fw * fh;
        if (noise_pct > 0 && $urandom_range(0, 1) == 1)
            push_item(CMD_FLUSH, SAMPLE_BITS'($urandom));
        for (int i = 0; i < total; i++)
        begin
            if (i > 0 && $urandom_range(0, 99) < noise_pct)
                push_item(CMD_FLUSH, SAMPLE_BITS'($urandom));
            // new sizes must wait for the next frame
            if (mid_cfg && i > 0 && i == total / 2)
            begin
                settle();
                random_regs();
            end
            push_item(CMD_SAMPLE, pick_sample(fill));
            counted++;
        end
        for (int i = 0; i <= fw; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                push_item(CMD_SAMPLE, SAMPLE_BITS'($urandom));
            push_item(CMD_FLUSH, SAMPLE_BITS'($urandom));
            counted++;
        end
    endtask

    initial
    begin : stimulus
        fill_t fill;
        int    noise;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values
        apb_access(1'b0, REG_MAP_WIDTH, '0);
        apb_access(1'b0, REG_MAP_HEIGHT, '0);
        apb_access(1'b0, REG_HEIGHT_SCALE, '0);

        // largest result, flushes while idle and while samples are owed
        program_regs(2, 2, 16'hFFFF);
        run_frame(50, FILL_MAX, 1'b0);
        settle();
        // zero scale, register writes in mid-frame
        program_regs(3, 2, 16'h0000);
        run_frame(0, FILL_EXTREME, 1'b1);
        run_frame(10, FILL_RANDOM, 1'b0);
        settle();

        // degenerate and extreme frame sizes
        program_regs(0, 3, 16'h0100);
        run_frame(20, FILL_EXTREME, 1'b0);
        settle();
        program_regs(1, 1, 16'($urandom));
        run_frame(20, FILL_RANDOM, 1'b0);
        settle();
        program_regs(5, 0, 16'h0100);
        run_frame(20, FILL_RANDOM, 1'b0);
        settle();
        // oversized width clamps to a full-width row
        program_regs(2047, 0, 16'hFFFF);
        run_frame(3, FILL_EXTREME, 1'b0);
        settle();
        quiet = 1'b1;
        program_regs(1, 64, 16'($urandom));
        run_frame(0, FILL_RANDOM, 1'b0);
        settle();
        quiet = 1'b0;

        // random frames, mostly well formed
        counted = 0;
        random_regs();
        while (counted < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                settle();
                random_regs();
            end
            quiet = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0, 1:    fill = FILL_EXTREME;
                2:       fill = FILL_MAX;
                default: fill = FILL_RANDOM;
            endcase
            noise = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(5, 15);
            run_frame(noise, fill, $urandom_range(0, 7) == 0);
        end
        quiet = 1'b0;
        settle();

        if (mismatch_count == 0 && heights_owed == 0)
            $display("box_filter_3x3_min_max regression: pass");
        else
            $display("box_filter_3x3_min_max regression: fail");
        $finish;
    end

endmodule
